### src/lsb_message_extractor_unit_defines.svh
// Assertion macros for the LSB message extractor checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LSB_MESSAGE_EXTRACTOR_UNIT_DEFINES_SVH
`define LSB_MESSAGE_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### src/lmx_pkg.sv
// Shared types and constants for the LSB message extractor.
// No dependencies; imported by every module of the block.
package lmx_pkg;

	localparam int unsigned LENGTH_BITS  = 32;
	localparam int unsigned PREFIX_W     = $clog2(LENGTH_BITS + 1);
	localparam int unsigned LEN_IDX_W    = $clog2(LENGTH_BITS);
	localparam int unsigned COUNT_W      = 32;
	localparam int unsigned NUM_CARRIERS = 3;
	localparam logic [4:0]  CARRIER_POS [NUM_CARRIERS] = '{5'd16, 5'd8, 5'd0};

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        start_of_image;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       last_byte;
	} byte_out_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] message_length;
		logic [PREFIX_W-1:0]    prefix_bits_seen;
		logic [7:0]             byte_accumulator;
		logic [2:0]             bit_position;
		logic [COUNT_W-1:0]     bytes_emitted;
		logic                   finished;
	} lmx_state_t;

endpackage

### src/lsb_message_extractor_unit.sv
// LSB message extractor top level: input register, state update, result register.
// An accepted pixel is held in the input register; the byte it completes is then held in the result register.
// Throughput: one pixel per cycle; a held result stalls intake only when
// the registered pixel would produce another byte.
// Reset: arst_n clears the extraction state and both valid flags at once.
// Depends on lmx_pkg and lmx_step.
module lsb_message_extractor_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  lmx_pkg::pixel_in_t pixel,
	output logic               result_valid,
	input  logic               result_ready,
	output lmx_pkg::byte_out_t result
);
	import lmx_pkg::*;

	logic       pixel_valid_s1;
	pixel_in_t  pixel_s1;
	lmx_state_t state_q;
	lmx_state_t state_d;
	logic       produce;
	byte_out_t  step_result;
	logic       out_free;
	logic       step_go;
	logic       result_valid_q;
	byte_out_t  result_q;

	lmx_step u_step (
		.state_cur  (state_q),
		.pixel      (pixel_s1),
		.state_next (state_d),
		.produce    (produce),
		.result     (step_result)
	);

	assign out_free    = !result_valid_q || result_ready;
	assign step_go     = pixel_valid_s1 && (out_free || !produce);
	assign pixel_ready = !pixel_valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			pixel_valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_ready && pixel_valid) begin
			pixel_s1 <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step_go) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_go && produce) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && produce) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### src/lmx_step.sv
// Per-pixel update: takes the three carrier bits of one pixel through the
// length prefix and byte gathering. Depends on lmx_pkg.
module lmx_step (
	input  lmx_pkg::lmx_state_t state_cur,
	input  lmx_pkg::pixel_in_t  pixel,
	output lmx_pkg::lmx_state_t state_next,
	output logic                produce,
	output lmx_pkg::byte_out_t  result
);
	import lmx_pkg::*;

	lmx_state_t st;
	logic       done;
	logic       hidden_bit;

	always_comb begin
		st         = pixel.start_of_image ? '0 : state_cur;
		done       = st.finished;
		produce    = 1'b0;
		result     = '0;
		hidden_bit = 1'b0;
		for (int k = 0; k < NUM_CARRIERS; k++) begin
			if (!done) begin
				hidden_bit = pixel.pixel_word[CARRIER_POS[k]];
				if (st.prefix_bits_seen < PREFIX_W'(LENGTH_BITS)) begin
					st.message_length[st.prefix_bits_seen[LEN_IDX_W-1:0]] =
						st.message_length[st.prefix_bits_seen[LEN_IDX_W-1:0]] | hidden_bit;
					st.prefix_bits_seen = st.prefix_bits_seen + PREFIX_W'(1);
					if (st.prefix_bits_seen == PREFIX_W'(LENGTH_BITS) &&
						st.message_length == '0) begin
						done = 1'b1;
					end
				end else begin
					st.byte_accumulator[st.bit_position] =
						st.byte_accumulator[st.bit_position] | hidden_bit;
					if (st.bit_position == 3'd7) begin
						st.bytes_emitted    = st.bytes_emitted + COUNT_W'(1);
						produce             = 1'b1;
						result.message_byte = st.byte_accumulator;
						result.last_byte    = (st.bytes_emitted == COUNT_W'(st.message_length));
						st.byte_accumulator = '0;
						st.bit_position     = '0;
						if (result.last_byte) begin
							done = 1'b1;
						end
					end else begin
						st.bit_position = st.bit_position + 3'd1;
					end
				end
			end
		end
		st.finished = done;
		state_next  = st;
	end

endmodule

### src/lmx_checker.sv
// Port-level checker for the LSB message extractor, bound to the top level.
// Depends on lmx_pkg and lsb_message_extractor_unit_defines.svh.
`include "lsb_message_extractor_unit_defines.svh"

module lmx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pixel_valid,
	input logic               pixel_ready,
	input lmx_pkg::pixel_in_t pixel,
	input logic               result_valid,
	input logic               result_ready,
	input lmx_pkg::byte_out_t result
);
	import lmx_pkg::*;

	logic pixel_request;
	logic pixel_stalled;
	logic result_stalled;

	assign pixel_request  = pixel_valid && pixel_ready;
	assign pixel_stalled  = pixel_valid && !pixel_ready;
	assign result_stalled = result_valid && !result_ready;

	// A stalled byte stays offered with its contents unchanged.
	`LMX_ASSERT_NEXT(a_result_hold, clk, arst_n, result_stalled, result_valid && $stable(result))
	// A waiting pixel request stays offered with its contents unchanged.
	`LMX_ASSERT_NEXT(a_pixel_hold, clk, arst_n, pixel_stalled, pixel_valid && $stable(pixel))
	// Intake closes only while a finished byte is waiting on the consumer.
	`LMX_ASSERT_NOW(a_ready_only_blocked_by_output, clk, arst_n, !pixel_ready, result_stalled)
	// A new byte is offered once the pixel request that made it has passed the input register and the result register.
	`LMX_ASSERT_NOW(a_result_from_request, clk, arst_n, $rose(result_valid), $past(pixel_request, 2))

endmodule

bind lsb_message_extractor_unit lmx_checker u_lmx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.pixel        (pixel),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### tb/sv/lsb_message_extractor_unit_tb.sv
// Self-checking testbench for lsb_message_extractor_unit: directed and random pixel streams,
// with an internal decoder that predicts each message byte and its last flag not given by the directed table.
// Depends on lmx_pkg and the lsb_message_extractor_unit RTL.
`timescale 1ns / 1ps

module lsb_message_extractor_unit_tb;
	import lmx_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1850;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned NUM_DIRECTED = 26;

	typedef struct packed {
		logic [31:0] word;
		logic        sof;
		logic        typed;
		logic        has_byte;
		byte_out_t   want;
	} dir_row_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      pixel_valid  = 1'b0;
	logic      pixel_ready;
	pixel_in_t pixel        = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	byte_out_t result;

	byte_out_t pending_bytes [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned useful_items   = 0;
	bit          no_idle        = 1'b0;

	logic [LENGTH_BITS-1:0] msg_len     = '0;
	logic [PREFIX_W-1:0]    prefix_seen = '0;
	logic [7:0]             acc_byte    = '0;
	logic [2:0]             bit_idx     = '0;
	logic [COUNT_W-1:0]     byte_count  = '0;
	bit                     msg_done    = 1'b0;

	// A zero length prefix, then a one-byte message followed by an ignored pixel.
	dir_row_t dir_rows [NUM_DIRECTED] = '{
		{32'hFFFE_FEFE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFE_FEFE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{32'h0001_0000, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0000_0001, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0001_0101, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'h0001_0101, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1},
		{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}
	};

	lsb_message_extractor_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Advances the decoder by one pixel and returns 1 when a byte completes.
	function automatic bit decode_hidden_bits(input pixel_in_t px, output byte_out_t emitted,
			output bit skipped);
		bit hb;
		bit got;
		bit stop;
		got = 1'b0;
		stop = 1'b0;
		emitted = '0;
		if (px.start_of_image) begin
			msg_len = '0;
			prefix_seen = '0;
			acc_byte = '0;
			bit_idx = '0;
			byte_count = '0;
			msg_done = 1'b0;
		end
		skipped = msg_done;
		if (!msg_done) begin
			for (int k = 0; k < NUM_CARRIERS; k++) begin
				if (!stop) begin
					hb = px.pixel_word[CARRIER_POS[k]];
					if (prefix_seen < LENGTH_BITS) begin
						if (hb)
							msg_len[prefix_seen[LEN_IDX_W-1:0]] = 1'b1;
						prefix_seen++;
						if (prefix_seen == LENGTH_BITS && msg_len == '0) begin
							msg_done = 1'b1;
							stop = 1'b1;
						end
					end else begin
						if (hb)
							acc_byte[bit_idx] = 1'b1;
						if (bit_idx == 3'd7) begin
							byte_count++;
							emitted.message_byte = acc_byte;
							emitted.last_byte = (byte_count == msg_len);
							got = 1'b1;
							acc_byte = '0;
							bit_idx = '0;
							if (emitted.last_byte) begin
								msg_done = 1'b1;
								stop = 1'b1;
							end
						end else begin
							bit_idx++;
						end
					end
				end
			end
		end
		return got;
	endfunction

	task automatic feed_pixel(input pixel_in_t px, input bit typed, input bit has_byte,
			input byte_out_t want);
		int unsigned gap;
		byte_out_t predicted;
		bit got;
		bit skipped;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel <= px;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
		got = decode_hidden_bits(px, predicted, skipped);
		if (typed) begin
			if (has_byte)
				pending_bytes.push_back(want);
		end else if (got) begin
			pending_bytes.push_back(predicted);
		end
		if (!skipped)
			useful_items++;
	endtask

	task automatic wait_bytes_drained();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	// Sends a length prefix and message, cut after keep pixels, then tail ignored pixels.
	task automatic send_image(input int unsigned len, input int unsigned keep,
			input int unsigned tail);
		bit stream [$];
		int unsigned npix;
		int unsigned idx;
		logic [7:0] data;
		pixel_in_t px;
		for (int i = 0; i < LENGTH_BITS; i++)
			stream.push_back(len[i]);
		for (int i = 0; i < len; i++) begin
			data = 8'($urandom);
			for (int j = 0; j < 8; j++)
				stream.push_back(data[j]);
		end
		npix = (stream.size() + 2) / 3;
		if (keep < npix)
			npix = keep;
		for (int i = 0; i < npix; i++) begin
			px.pixel_word = $urandom;
			px.start_of_image = (i == 0);
			for (int k = 0; k < NUM_CARRIERS; k++) begin
				idx = 3 * i + k;
				px.pixel_word[CARRIER_POS[k]] = (idx < stream.size()) ? stream[idx] :
					1'($urandom_range(0, 1));
			end
			feed_pixel(px, 1'b0, 1'b0, '0);
		end
		for (int t = 0; t < tail; t++) begin
			px.pixel_word = $urandom;
			px.start_of_image = 1'b0;
			feed_pixel(px, 1'b0, 1'b0, '0);
		end
	endtask

	initial begin
		byte_out_t seen;
		byte_out_t want;
		int unsigned stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			seen = result;
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					seen.message_byte, seen.last_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (seen.message_byte !== want.message_byte)
					report_mismatch($sformatf("message_byte %02h, expected %02h",
						seen.message_byte, want.message_byte));
				if (seen.last_byte !== want.last_byte)
					report_mismatch($sformatf("last_byte %0b, expected %0b",
						seen.last_byte, want.last_byte));
			end
		end
	end

	initial begin
		pixel_in_t px;
		int unsigned sel;
		int unsigned len;
		int unsigned count;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			px.pixel_word = dir_rows[i].word;
			px.start_of_image = dir_rows[i].sof;
			feed_pixel(px, dir_rows[i].typed, dir_rows[i].has_byte, dir_rows[i].want);
		end
		wait_bytes_drained();

		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 5)
				len = 0;
			else if (sel < 10)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(1, 12);
			if (sel < 70) begin
				send_image(len, 32'hFFFF_FFFF, $urandom_range(0, 3));
			end else if (sel < 85) begin
				send_image(len, $urandom_range(1, (LENGTH_BITS + 8 * len + 2) / 3), 0);
			end else begin
				count = $urandom_range(1, 30);
				for (int i = 0; i < count; i++) begin
					px.pixel_word = $urandom;
					px.start_of_image = ($urandom_range(0, 7) == 0);
					feed_pixel(px, 1'b0, 1'b0, '0);
				end
			end
			if ($urandom_range(0, 9) == 0)
				wait_bytes_drained();
		end

		wait_bytes_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_bytes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/lmx_pkg.sv
src/lmx_step.sv
src/lsb_message_extractor_unit.sv
src/lmx_checker.sv
tb/sv/lsb_message_extractor_unit_tb.sv
